// ----- src/afcd_pkg.sv -----
// afcd_pkg: shared types, constants and codes of the api frame checksum decoder
// no dependencies; imported by every module of the block

package afcd_pkg;

    // frame layout and checksum constants
    localparam int          MAX_FRAME_BYTES_DEF = 255;
    localparam int          HEAD_LEN            = 6;
    localparam int          PAYLOAD_OFFSET      = 5;
    localparam logic [7:0]  GOOD_SUM            = 8'hFF;
    localparam logic [7:0]  PAYLOAD_BIAS        = 8'd6;

    // minimum frame lengths, checksum included
    localparam logic [7:0]  AT_MIN_LEN          = 8'd6;
    localparam logic [7:0]  MODEM_MIN_LEN       = 8'd3;
    localparam logic [7:0]  TX_MIN_LEN          = 8'd7;

    // reset values of the type registers
    localparam logic [7:0]  TYPE_AT_RESET       = 8'd136;
    localparam logic [7:0]  TYPE_MODEM_RESET    = 8'd138;
    localparam logic [7:0]  TYPE_TX_RESET       = 8'd139;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TYPE_AT    = 2'd0,
        REG_TYPE_MODEM = 2'd1,
        REG_TYPE_TX    = 2'd2
    } cfg_index_t;

    // error codes of a result
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CHECKSUM = 2'd1,
        ERR_TYPE     = 2'd2,
        ERR_SHORT    = 2'd3
    } error_kind_t;

    // one input transaction
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } byte_item_t;

    // one result transaction
    typedef struct packed {
        logic        frame_ok;
        error_kind_t error_kind;
        logic [7:0]  frame_type;
        logic [7:0]  frame_id;
        logic [7:0]  at_cmd_first;
        logic [7:0]  at_cmd_second;
        logic [7:0]  status_byte;
        logic [7:0]  payload_len;
        logic        payload_present;
    } result_item_t;

    // type code registers
    typedef struct packed {
        logic [7:0] type_at_response;
        logic [7:0] type_modem_status;
        logic [7:0] type_tx_status;
    } cfg_regs_t;

    // frame state including the byte being taken
    typedef struct packed {
        logic [7:0]                    byte_sum;
        logic [7:0]                    byte_count;
        logic [HEAD_LEN-1:0][7:0]      head_bytes;
    } frame_view_t;

endpackage

// ----- src/afcd_accum.sv -----
// afcd_accum: running byte sum, saturating byte count and capture of bytes 0 to 5
// depends on afcd_pkg

module afcd_accum #(
    parameter int MaxFrameBytes = afcd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  afcd_pkg::byte_item_t  item,
    output afcd_pkg::frame_view_t view
);
    import afcd_pkg::*;

    localparam logic [7:0] MAX_COUNT = 8'(MaxFrameBytes);

    logic [7:0]               byte_sum_reg;
    logic [7:0]               byte_count_reg;
    logic [HEAD_LEN-1:0][7:0] head_bytes_reg;

    // frame state as it stands once the current byte is counted
    always_comb
    begin
        view.byte_sum   = byte_sum_reg + item.frame_byte;
        view.byte_count = (byte_count_reg < MAX_COUNT) ? byte_count_reg + 8'd1
                                                       : byte_count_reg;
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            view.head_bytes[i] = (byte_count_reg == 8'(i)) ? item.frame_byte
                                                           : head_bytes_reg[i];
        end
    end

    // sum and count, cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_sum_reg   <= '0;
            byte_count_reg <= '0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                byte_sum_reg   <= '0;
                byte_count_reg <= '0;
            end
            else
            begin
                byte_sum_reg   <= view.byte_sum;
                byte_count_reg <= view.byte_count;
            end
        end
    end

    // header capture; only bytes written in the current frame are ever used
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            head_bytes_reg <= view.head_bytes;
        end
    end

    // the count never runs past the frame limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_COUNT)
        else $error("byte count above frame limit");

endmodule

// ----- src/afcd_decode.sv -----
// afcd_decode: checksum check and decode of the frame type into a result
// depends on afcd_pkg

module afcd_decode (
    input  afcd_pkg::frame_view_t  view,
    input  afcd_pkg::cfg_regs_t    cfg,
    output afcd_pkg::result_item_t res
);
    import afcd_pkg::*;

    logic [7:0] len;
    logic [7:0] ftype;

    assign len   = view.byte_count;
    assign ftype = view.head_bytes[0];

    // error priority: checksum, type, length
    always_comb
    begin
        res            = '0;
        res.error_kind = ERR_NONE;
        res.frame_type = ftype;
        if (view.byte_sum != GOOD_SUM)
        begin
            res.error_kind = ERR_CHECKSUM;
        end
        else if (ftype == cfg.type_at_response)
        begin
            if (len < AT_MIN_LEN)
            begin
                res.error_kind = ERR_SHORT;
            end
            else
            begin
                res.frame_ok        = 1'b1;
                res.frame_id        = view.head_bytes[1];
                res.at_cmd_first    = view.head_bytes[2];
                res.at_cmd_second   = view.head_bytes[3];
                res.status_byte     = view.head_bytes[4];
                res.payload_len     = len - PAYLOAD_BIAS;
                res.payload_present = (len != PAYLOAD_BIAS);
            end
        end
        else if (ftype == cfg.type_modem_status)
        begin
            if (len < MODEM_MIN_LEN)
            begin
                res.error_kind = ERR_SHORT;
            end
            else
            begin
                res.frame_ok    = 1'b1;
                res.status_byte = view.head_bytes[1];
            end
        end
        else if (ftype == cfg.type_tx_status)
        begin
            if (len < TX_MIN_LEN)
            begin
                res.error_kind = ERR_SHORT;
            end
            else
            begin
                res.frame_ok    = 1'b1;
                res.frame_id    = view.head_bytes[1];
                res.status_byte = view.head_bytes[PAYLOAD_OFFSET];
            end
        end
        else
        begin
            res.error_kind = ERR_TYPE;
        end
    end

endmodule

// ----- src/afcd_out_buf.sv -----
// afcd_out_buf: result register with one skid entry behind it
// depends on afcd_pkg

module afcd_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  afcd_pkg::result_item_t push_item,
    output logic                   full,
    output logic                   result_valid,
    input  logic                   result_stall,
    output afcd_pkg::result_item_t result_item
);
    import afcd_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_item_t out_item_reg;
    result_item_t out_item_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    result_item_t skid_item_reg;
    result_item_t skid_item_next;
    logic         pop;

    assign pop = out_valid_reg && !result_stall;

    // refill the result register from skid first, then from a new result
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = push;
                skid_item_next  = push_item;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // skid entry is only used behind a held result
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without result register");

    // a result arriving while both entries are full would be lost
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |-> !push)
        else $error("result pushed into full buffer");

endmodule

// ----- src/api_frame_checksum_decoder_top.sv -----
// api_frame_checksum_decoder_top: top level of the api frame checksum decoder
// depends on afcd_pkg, afcd_accum, afcd_decode, afcd_out_buf
//
// Usage:
//   byte channel (byte_valid, byte_stall, byte_item): one frame byte per
//   transaction, type byte first, checksum byte flagged by last_byte.
//   result channel (result_valid, result_stall, result_item): one transaction
//   per frame, issued for the byte with last_byte set.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes the three
//   type code registers; cfg_ready is always high. Write only while idle.
// Timing:
//   one byte is taken every cycle while byte_stall is low; the running sum and
//   capture are updated in the cycle the byte is taken, and the result is
//   registered in the result register, or in the skid entry while a result waits.
//   A result register plus one skid entry decouple the two channels:
//   bytes keep flowing while a result waits, and byte_stall rises only
//   when both entries hold results.
// Reset:
//   rst_n clears sum, count and both result entries and loads the default
//   type codes; there is no clearing pass, the block is ready at once.

module api_frame_checksum_decoder_top #(
    parameter int MaxFrameBytes = afcd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  afcd_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output afcd_pkg::result_item_t result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  afcd_pkg::cfg_index_t   cfg_index,
    input  logic [7:0]             cfg_data
);
    import afcd_pkg::*;

    cfg_regs_t    cfg_reg;
    frame_view_t  view;
    result_item_t decoded;
    logic         take;
    logic         buf_full;

    assign cfg_ready  = 1'b1;
    assign byte_stall = buf_full;
    assign take       = byte_valid && !byte_stall;

    // type code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.type_at_response  <= TYPE_AT_RESET;
            cfg_reg.type_modem_status <= TYPE_MODEM_RESET;
            cfg_reg.type_tx_status    <= TYPE_TX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TYPE_AT:    cfg_reg.type_at_response  <= cfg_data;
                REG_TYPE_MODEM: cfg_reg.type_modem_status <= cfg_data;
                REG_TYPE_TX:    cfg_reg.type_tx_status    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // running frame state
    afcd_accum #(
        .MaxFrameBytes (MaxFrameBytes)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_item),
        .view  (view)
    );

    // checksum and type decode
    afcd_decode u_decode (
        .view (view),
        .cfg  (cfg_reg),
        .res  (decoded)
    );

    // result register and skid
    afcd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (take && byte_item.last_byte),
        .push_item    (decoded),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // frame_ok and error_kind agree
    a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.frame_ok == (result_item.error_kind == ERR_NONE)))
        else $error("frame_ok disagrees with error_kind");

    // payload flag follows payload length
    a_payload_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.payload_present == (result_item.payload_len != 8'd0)))
        else $error("payload_present disagrees with payload_len");

endmodule

// ----- dv/api_frame_checksum_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// api_frame_checksum_decoder_top_tb: self-checking bench for the api frame checksum decoder
// depends on afcd_pkg and api_frame_checksum_decoder_top; drives random frames with idling
// on both channels and checks every decoded frame against an in-bench frame decoder

module api_frame_checksum_decoder_top_tb;

    import afcd_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;

    // decodes frames from the accepted byte stream and checks the block's results
    class frame_result_board;
        logic [7:0]   type_at;
        logic [7:0]   type_modem;
        logic [7:0]   type_tx;
        logic [7:0]   running_sum;
        int unsigned  bytes_seen;
        logic [7:0]   head [HEAD_LEN];
        result_item_t pending_results [$];
        int unsigned  mismatches;
        int unsigned  results_checked;

        function new();
            type_at         = TYPE_AT_RESET;
            type_modem      = TYPE_MODEM_RESET;
            type_tx         = TYPE_TX_RESET;
            mismatches      = 0;
            results_checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            running_sum = 8'h00;
            bytes_seen  = 0;
            foreach (head[i]) head[i] = 8'h00;
        endfunction

        function void set_type(input cfg_index_t idx, input logic [7:0] code);
            case (idx)
                REG_TYPE_AT:    type_at    = code;
                REG_TYPE_MODEM: type_modem = code;
                REG_TYPE_TX:    type_tx    = code;
                default:        ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // note one accepted byte transaction; a last byte yields one decoded frame
        function void take_byte(input byte_item_t item);
            result_item_t r;
            int unsigned  len;
            running_sum = running_sum + item.frame_byte;
            if (bytes_seen < HEAD_LEN) head[bytes_seen] = item.frame_byte;
            if (bytes_seen < MAX_FRAME_BYTES_DEF) bytes_seen++;
            if (!item.last_byte) return;

            len          = bytes_seen;
            r            = '0;
            r.error_kind = ERR_NONE;
            r.frame_type = head[0];
            // checksum first, then type match in register order, then length
            if (running_sum != GOOD_SUM)
            begin
                r.error_kind = ERR_CHECKSUM;
            end
            else if (head[0] == type_at)
            begin
                if (len < AT_MIN_LEN)
                begin
                    r.error_kind = ERR_SHORT;
                end
                else
                begin
                    r.frame_ok        = 1'b1;
                    r.frame_id        = head[1];
                    r.at_cmd_first    = head[2];
                    r.at_cmd_second   = head[3];
                    r.status_byte     = head[4];
                    r.payload_len     = 8'(len - PAYLOAD_BIAS);
                    r.payload_present = (r.payload_len != 8'h00);
                end
            end
            else if (head[0] == type_modem)
            begin
                if (len < MODEM_MIN_LEN)
                begin
                    r.error_kind = ERR_SHORT;
                end
                else
                begin
                    r.frame_ok    = 1'b1;
                    r.status_byte = head[1];
                end
            end
            else if (head[0] == type_tx)
            begin
                if (len < TX_MIN_LEN)
                begin
                    r.error_kind = ERR_SHORT;
                end
                else
                begin
                    r.frame_ok    = 1'b1;
                    r.frame_id    = head[1];
                    r.status_byte = head[PAYLOAD_OFFSET];
                end
            end
            else
            begin
                r.error_kind = ERR_TYPE;
            end
            pending_results.push_back(r);
            clear_frame();
        endfunction

        task report(input string msg);
            if (mismatches < 50) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want)
                report($sformatf("frame %0d %s got %0h want %0h",
                                 results_checked, name, got, want));
        endtask

        // compare one accepted result transaction with the oldest decoded frame
        task check_result(input result_item_t got);
            result_item_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no frame pending, type %0h", got.frame_type));
                return;
            end
            want = pending_results.pop_front();
            check_field("frame_ok", got.frame_ok, want.frame_ok);
            check_field("error_kind", got.error_kind, want.error_kind);
            check_field("frame_type", got.frame_type, want.frame_type);
            check_field("frame_id", got.frame_id, want.frame_id);
            check_field("at_cmd_first", got.at_cmd_first, want.at_cmd_first);
            check_field("at_cmd_second", got.at_cmd_second, want.at_cmd_second);
            check_field("status_byte", got.status_byte, want.status_byte);
            check_field("payload_len", got.payload_len, want.payload_len);
            check_field("payload_present", got.payload_present, want.payload_present);
            results_checked++;
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         byte_valid;
    logic         byte_stall;
    byte_item_t   byte_item;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_valid;
    logic         cfg_ready;
    cfg_index_t   cfg_index;
    logic [7:0]   cfg_data;

    frame_result_board board;
    logic [7:0]        frame_bytes [$];
    bit                sender_idle_on;
    bit                sink_idle_on;
    int unsigned       stall_left;
    int unsigned       bytes_sent;
    int unsigned       cycle_count;

    api_frame_checksum_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side stall bursts
    initial stall_left = 0;
    always @(posedge clk)
    begin : sink_stall
        int unsigned nxt;
        nxt = stall_left;
        if (nxt != 0)
            nxt--;
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
            nxt = $urandom_range(1, 11);
        stall_left   <= nxt;
        result_stall <= (nxt != 0);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result_item);
    end

    // one byte transaction, with an optional idle burst ahead of it
    task push_byte(input logic [7:0] value, input bit last);
        if (sender_idle_on && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        byte_valid           <= 1'b1;
        byte_item.frame_byte <= value;
        byte_item.last_byte  <= last;
        do @(posedge clk); while (byte_stall);
        board.take_byte('{frame_byte: value, last_byte: last});
        bytes_sent++;
    endtask

    // build a frame of n bytes and send it; fill < 0 gives random body bytes
    task send_frame(input logic [7:0] ftype, input int n, input bit good_sum, input int fill);
        logic [7:0] sum;
        logic [7:0] body;
        frame_bytes.delete();
        frame_bytes.push_back(ftype);
        sum = ftype;
        for (int i = 1; i < n - 1; i++)
        begin
            body = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            frame_bytes.push_back(body);
            sum = sum + body;
        end
        if (n > 1)
        begin
            body = GOOD_SUM - sum;
            if (!good_sum) body = body ^ 8'($urandom_range(1, 255));
            frame_bytes.push_back(body);
        end
        foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // random frame, mostly of a configured type and short
    task random_frame();
        int         pick;
        int         n;
        logic [7:0] ftype;
        pick = $urandom_range(0, 99);
        if (pick < 30)      ftype = board.type_at;
        else if (pick < 50) ftype = board.type_modem;
        else if (pick < 70) ftype = board.type_tx;
        else                ftype = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 70)      n = $urandom_range(1, 9);
        else if (pick < 95) n = $urandom_range(10, 30);
        else                n = $urandom_range(31, 100);
        send_frame(ftype, n, $urandom_range(0, 99) < 85, -1);
    endtask

    // stop sending and wait until every decoded frame has been checked
    task settle_results();
        byte_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_type(input cfg_index_t idx, input logic [7:0] code);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        board.set_type(idx, code);
    endtask

    task program_types(input logic [7:0] at_code, input logic [7:0] modem_code,
                       input logic [7:0] tx_code);
        write_type(REG_TYPE_AT, at_code);
        write_type(REG_TYPE_MODEM, modem_code);
        write_type(REG_TYPE_TX, tx_code);
        cfg_valid <= 1'b0;
    endtask

    // one configuration phase of random frames
    task run_phase(input logic [7:0] at_code, input logic [7:0] modem_code,
                   input logic [7:0] tx_code, input int unsigned budget,
                   input bit sender_idle, input bit sink_idle);
        int unsigned start;
        settle_results();
        program_types(at_code, modem_code, tx_code);
        sender_idle_on = sender_idle;
        sink_idle_on   = sink_idle;
        start          = bytes_sent;
        while (bytes_sent - start < budget) random_frame();
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [7:0] code;
        board          = new();
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_item      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TYPE_AT;
        cfg_data       = 8'h00;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        bytes_sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at reset type codes
        send_frame(8'hFF, 1, 1'b1, -1);           // single byte with good sum, unknown type
        send_frame(TYPE_MODEM_RESET, 3, 1'b1, 8'hFF);
        send_frame(TYPE_MODEM_RESET, 2, 1'b1, -1); // modem status too short
        send_frame(TYPE_AT_RESET, 5, 1'b1, 8'h00); // at response too short
        send_frame(TYPE_AT_RESET, 7, 1'b1, 8'hFF); // one payload byte
        send_frame(TYPE_TX_RESET, 7, 1'b1, -1);

        // random phases across type code settings
        run_phase(8'h00, 8'h00, 8'h00, 40, 1'b1, 1'b1);
        run_phase(8'hFF, 8'hFF, 8'hFF, 40, 1'b1, 1'b0);
        run_phase(8'h00, 8'hFF, 8'h7F, 40, 1'b0, 1'b1);
        send_frame(8'h00, $urandom_range(256, 262), 1'b1, -1); // overlong at response
        code = 8'($urandom_range(0, 255));
        run_phase(8'($urandom_range(0, 255)), code, code, 40, 1'b1, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 40, 1'b0, 1'b0);
        run_phase(TYPE_AT_RESET, TYPE_MODEM_RESET, TYPE_TX_RESET, 40, 1'b1, 1'b1);
        send_frame(TYPE_AT_RESET, 255, 1'b1, -1);  // longest frame before saturation
        // closing stretch with no idling
        run_phase(TYPE_AT_RESET, TYPE_MODEM_RESET, TYPE_TX_RESET, 40, 1'b0, 1'b0);

        settle_results();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
